>>> src/mkd_pkg.sv
// ----------------------------------------------------------------------------
// mkd_pkg - shared types and constants of the Morse key letter decoder
// Key modes, symbol codes, register map, configuration and result structs,
// and the Morse code to letter / seven-segment lookup.
// ----------------------------------------------------------------------------
package mkd_pkg;

    localparam int CFG_W     = 16;  // width of each configuration register
    localparam int APB_AW    = 4;   // byte address bits for three registers
    localparam int APB_DW    = 32;
    localparam int LETTER_W  = 5;
    localparam int SEG_W     = 8;
    localparam int SYM_W     = 2;
    localparam int SYM_DEPTH = 4;
    localparam int SYM_CNT_W = 3;   // holds 0..4

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd50;
    localparam logic [CFG_W-1:0] DASH_RESET     = 16'd300;
    localparam logic [CFG_W-1:0] GAP_RESET      = 16'd1000;

    // register index, taken from paddr[3:2]
    localparam logic [1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [1:0] REG_DASH     = 2'd1;
    localparam logic [1:0] REG_GAP      = 2'd2;

    // symbol buffer entries
    localparam logic [SYM_W-1:0] SYM_EMPTY = 2'd0;
    localparam logic [SYM_W-1:0] SYM_DOT   = 2'd1;
    localparam logic [SYM_W-1:0] SYM_DASH  = 2'd2;

    localparam logic [SYM_CNT_W-1:0] SYM_FULL = 3'd4;

    typedef enum logic [1:0] {
        KM_RELEASED = 2'd0,
        KM_DEBOUNCE = 2'd1,
        KM_HELD     = 2'd2,
        KM_WAITING  = 2'd3
    } t_key_mode;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ticks;
        logic [CFG_W-1:0] dash_threshold;
        logic [CFG_W-1:0] gap_timeout;
    } t_cfg;

    typedef struct packed {
        logic [LETTER_W-1:0] letter_index;
        logic [SEG_W-1:0]    segment_pattern;
    } t_result;

    // code = sym0 | sym1<<2 | sym2<<4 | sym3<<6, first symbol in the low bits
    function automatic t_result mkd_decode(input logic [4*SYM_W-1:0] code);
        t_result r;
        unique case (code)
            8'h09:   r = '{5'd1,  8'h77};  // A .-
            8'h56:   r = '{5'd2,  8'h7C};  // B -...
            8'h66:   r = '{5'd3,  8'h39};  // C -.-.
            8'h16:   r = '{5'd4,  8'h5E};  // D -..
            8'h01:   r = '{5'd5,  8'h79};  // E .
            8'h65:   r = '{5'd6,  8'h71};  // F ..-.
            8'h1A:   r = '{5'd7,  8'h6F};  // G --.
            8'h55:   r = '{5'd8,  8'h76};  // H ....
            8'h05:   r = '{5'd9,  8'h06};  // I ..
            8'hA9:   r = '{5'd10, 8'h0E};  // J .---
            8'h26:   r = '{5'd11, 8'h70};  // K -.-
            8'h59:   r = '{5'd12, 8'h38};  // L .-..
            8'h0A:   r = '{5'd13, 8'h55};  // M --
            8'h06:   r = '{5'd14, 8'h37};  // N -.
            8'h2A:   r = '{5'd15, 8'h3F};  // O ---
            8'h69:   r = '{5'd16, 8'h73};  // P .--.
            8'h9A:   r = '{5'd17, 8'h67};  // Q --.-
            8'h19:   r = '{5'd18, 8'h31};  // R .-.
            8'h15:   r = '{5'd19, 8'h6D};  // S ...
            8'h02:   r = '{5'd20, 8'h78};  // T -
            8'h25:   r = '{5'd21, 8'h3E};  // U ..-
            8'h95:   r = '{5'd22, 8'h2A};  // V ...-
            8'h29:   r = '{5'd23, 8'h6A};  // W .--
            8'h96:   r = '{5'd24, 8'h14};  // X -..-
            8'hA6:   r = '{5'd25, 8'h6E};  // Y -.--
            8'h5A:   r = '{5'd26, 8'h1B};  // Z --..
            default: r = '{5'd0,  8'h00};  // unknown or empty
        endcase
        return r;
    endfunction

endpackage

>>> src/morse_key_letter_decoder.sv
// ----------------------------------------------------------------------------
// morse_key_letter_decoder - Morse key to letter and seven-segment decoder
// Samples the key once per tick beat, classes presses into dots and dashes,
// and emits the letter and its segment pattern after the letter gap.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------------------------
//  in      | sink      | i_in_valid / o_in_stall   | i_key_down
//  out     | source    | o_out_valid / i_out_stall | o_letter_index,
//          |           |                           | o_segment_pattern
//  cfg     | APB slave | psel/penable/pready       | paddr, pwdata, prdata
//
//  One beat per cycle sustained while the letter output is not stalled. A key
//  beat is captured in the input register, runs through the state update and
//  lookup once the output side can take it, and a letter lands in the output
//  register at the end of that step, from which it drives o_out_valid.
//  Reset (synchronous, active low) clears the pipeline valids, the key state
//  and loads the register defaults (50 / 300 / 1000).
//  o_in_stall rises only while a beat waits in the input register and the
//  output register holds a letter that is stalled.
// ----------------------------------------------------------------------------
module morse_key_letter_decoder
    import mkd_pkg::*;
#(
    parameter int COUNTER_WIDTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // key sample channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_key_down,
    // letter channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [LETTER_W-1:0] o_letter_index,
    output logic [SEG_W-1:0]    o_segment_pattern,
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready
);

    t_cfg    cfg;
    logic    r_in_valid, n_in_valid;
    logic    r_key;
    logic    r_out_valid;
    t_result r_out;
    logic    out_ready;   // output register can take a new beat
    logic    step;        // input register drains into the core
    logic    in_accept;
    logic    core_valid;
    t_result core_result;

    mkd_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // handshake: the input register drains whenever the output side can take
    // a beat, so a stalled letter only holds back the next sample
    assign out_ready  = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && out_ready;
    assign o_in_stall = r_in_valid && !out_ready;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_accept) begin
            n_in_valid = 1'b1;
        end else if (step) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    // key sample payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_key <= i_key_down;
        end
    end

    mkd_core #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_key_down     (r_key),
        .i_cfg          (cfg),
        .o_result_valid (core_valid),
        .o_result       (core_result)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= step && core_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && step && core_valid) begin
            r_out <= core_result;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_letter_index    = r_out.letter_index;
    assign o_segment_pattern = r_out.segment_pattern;

endmodule

>>> src/mkd_cfg_regs.sv
// ----------------------------------------------------------------------------
// mkd_cfg_regs - APB configuration registers
// Debounce length, dash threshold and letter gap timeout; zero wait states.
// ----------------------------------------------------------------------------
module mkd_cfg_regs
    import mkd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks <= DEBOUNCE_RESET;
            r_cfg.dash_threshold <= DASH_RESET;
            r_cfg.gap_timeout    <= GAP_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_DEBOUNCE: r_cfg.debounce_ticks <= pwdata[CFG_W-1:0];
                REG_DASH:     r_cfg.dash_threshold <= pwdata[CFG_W-1:0];
                REG_GAP:      r_cfg.gap_timeout    <= pwdata[CFG_W-1:0];
                default:      ;  // unmapped, ignored
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_DEBOUNCE: prdata = APB_DW'(r_cfg.debounce_ticks);
            REG_DASH:     prdata = APB_DW'(r_cfg.dash_threshold);
            REG_GAP:      prdata = APB_DW'(r_cfg.gap_timeout);
            default:      prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

>>> src/mkd_core.sv
// ----------------------------------------------------------------------------
// mkd_core - key state machine, symbol buffer and letter lookup
// Advances one key sample per step; flags a result when the letter gap ends.
// ----------------------------------------------------------------------------
module mkd_core
    import mkd_pkg::*;
#(
    parameter int COUNTER_WIDTH = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  logic    i_key_down,
    input  t_cfg    i_cfg,
    output logic    o_result_valid,
    output t_result o_result
);

    localparam int CW    = COUNTER_WIDTH;
    localparam int CMP_W = (CW > CFG_W) ? CW : CFG_W;
    localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

    t_key_mode                        r_mode, n_mode;
    logic [CW-1:0]                    r_press, n_press;
    logic [CW-1:0]                    r_hold, n_hold;
    logic [CW-1:0]                    r_gap, n_gap;
    logic [SYM_DEPTH-1:0][SYM_W-1:0]  r_buf, n_buf;
    logic [SYM_CNT_W-1:0]             r_count, n_count;
    logic [SYM_W-1:0]                 sym;

    function automatic logic [CW-1:0] bump(input logic [CW-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= KM_RELEASED;
            r_press <= '0;
            r_hold  <= '0;
            r_gap   <= '0;
            r_buf   <= '0;
            r_count <= '0;
        end else begin
            r_mode  <= n_mode;
            r_press <= n_press;
            r_hold  <= n_hold;
            r_gap   <= n_gap;
            r_buf   <= n_buf;
            r_count <= n_count;
        end
    end

    assign sym = (CMP_W'(r_hold) > CMP_W'(i_cfg.dash_threshold)) ? SYM_DASH : SYM_DOT;

    always_comb begin
        n_mode         = r_mode;
        n_press        = r_press;
        n_hold         = r_hold;
        n_gap          = r_gap;
        n_buf          = r_buf;
        n_count        = r_count;
        o_result_valid = 1'b0;
        o_result       = mkd_decode({r_buf[3], r_buf[2], r_buf[1], r_buf[0]});
        if (i_step) begin
            unique case (r_mode)
                KM_DEBOUNCE: begin
                    // counts on either key level; a bounce up is ignored
                    n_press = bump(r_press);
                    if (i_key_down &&
                        CMP_W'(n_press) >= CMP_W'(i_cfg.debounce_ticks)) begin
                        n_mode = KM_HELD;
                    end
                end
                KM_HELD: begin
                    if (i_key_down) begin
                        n_press = bump(r_press);
                        n_hold  = n_press;
                    end else begin
                        if (r_count < SYM_FULL) begin
                            n_buf[r_count[1:0]] = sym;
                            n_count = r_count + 1'b1;
                        end else begin
                            // fifth symbol drops the whole letter
                            n_buf   = '0;
                            n_count = '0;
                            n_hold  = '0;
                        end
                        n_gap  = '0;
                        n_mode = KM_WAITING;
                    end
                end
                KM_RELEASED, KM_WAITING: begin
                    if (i_key_down) begin
                        n_press = '0;
                        n_hold  = '0;
                        n_gap   = '0;
                        n_mode  = KM_DEBOUNCE;
                    end else if (r_mode == KM_WAITING) begin
                        n_gap = bump(r_gap);
                        if (CMP_W'(n_gap) >= CMP_W'(i_cfg.gap_timeout)) begin
                            o_result_valid = 1'b1;
                            n_buf   = '0;
                            n_count = '0;
                            n_gap   = '0;
                            n_hold  = '0;
                            n_mode  = KM_RELEASED;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // a letter always leaves the decoder empty and released
    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> (r_mode == KM_RELEASED) && (r_count == '0) && (r_buf == '0))
        else $error("state not cleared after letter");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= SYM_FULL)
        else $error("symbol count overflow");

    a_seg_matches_letter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> ((o_result.letter_index == '0) ==
                            (o_result.segment_pattern == '0)))
        else $error("segment pattern inconsistent with letter");

    a_no_result_unless_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (r_mode == KM_WAITING) && !i_key_down)
        else $error("letter emitted outside gap wait");

endmodule
